// ===== hdl/gbl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian blur package
// Shared constants, payload structs and helper functions for the 5x5 RGB
// Gaussian blur block.
// ----------------------------------------------------------------------------
package gbl_pkg;

    // Geometry of the frame and the filter window.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4095;
    localparam int MIN_SIZE   = 5;
    localparam int TAPS       = 5;
    localparam int EDGE       = 2;
    localparam int LINES      = TAPS - 1;
    localparam int COEFS      = 6;

    // Field and counter widths.
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int FW_FIELD_W = 11;
    localparam int FH_FIELD_W = 12;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W      = FH_FIELD_W;
    localparam int PEND_W     = $clog2(2 * MAX_WIDTH + 4);
    localparam int RING_DEPTH = 2 ** PEND_W;

    // Arithmetic widths: class sums hold up to eight pixels.
    localparam int SUM_W  = PIX_W + 3;
    localparam int PROD_W = SUM_W + COEF_W;
    localparam int ACC_W  = PROD_W + 3;

    // Reset values of the configuration registers.
    localparam logic [WID_W-1:0]  WIDTH_RST  = WID_W'(640);
    localparam logic [ROW_W-1:0]  HEIGHT_RST = ROW_W'(480);
    localparam logic [COEF_W-1:0] COEF_RST [COEFS] =
        '{16'd16384, 16'd4096, 16'd2048, 16'd1024, 16'd512, 16'd256};

    // Coefficient class for each offset pair (|di|, |dj|) from the center.
    localparam logic [2:0] TAP_CLASS [3][3] =
        '{'{3'd0, 3'd1, 3'd3}, '{3'd1, 3'd2, 3'd4}, '{3'd3, 3'd4, 3'd5}};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 4'd0,
        REG_FRAME_HEIGHT = 4'd1,
        REG_COEF_D0      = 4'd2,
        REG_COEF_D1      = 4'd3,
        REG_COEF_D2      = 4'd4,
        REG_COEF_D4      = 4'd5,
        REG_COEF_D5      = 4'd6,
        REG_COEF_D8      = 4'd7
    } cfg_reg_t;

    // One RGB pixel.
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pix_t;

    // Input transaction payload.
    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             frame_end;
    } out_item_t;

    // A window column (index 0 is the oldest row) and a line store word
    // (index k holds the pixel k+1 rows above).
    typedef pix_t [TAPS-1:0]  column_t;
    typedef pix_t [LINES-1:0] line_word_t;

    // One color channel of the whole window, [row][column].
    typedef logic [TAPS-1:0][TAPS-1:0][PIX_W-1:0] chan_win_t;
    typedef logic [COEFS-1:0][COEF_W-1:0]         coef_arr_t;

    // Pipeline stage tag carried alongside the data path.
    typedef struct packed {
        logic             push;
        logic             emit;
        logic             filter;
        logic             frame_end;
        logic [COL_W-1:0] col;
        pix_t             pix;
    } stage_t;

    // Coefficient class of window tap (di, dj).
    function automatic logic [2:0] tap_class(input int di, input int dj);
        int ai;
        int aj;
        ai = (di >= EDGE) ? di - EDGE : EDGE - di;
        aj = (dj >= EDGE) ? dj - EDGE : EDGE - dj;
        return TAP_CLASS[ai][aj];
    endfunction

endpackage

// ===== hdl/gbl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory: one write port, one read port with registered
// read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module gbl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port (read returns the old word).
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/gbl_win_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window column cell
// Holds one five-pixel column of the filter window and hands it to its
// neighbor whenever a new pixel enters the window.
// ----------------------------------------------------------------------------
module gbl_win_cell (
    input  logic             clk,
    input  logic             shift,
    input  gbl_pkg::column_t col_in,
    output gbl_pkg::column_t col_out
);

    gbl_pkg::column_t col_reg;

    // Load the neighbor's column on each window shift.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

// ===== hdl/gbl_conv_chan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel convolver
// Weighted 5x5 sum for one color channel: taps of equal weight are added
// first, then six products are formed, summed, floored and saturated.
// ----------------------------------------------------------------------------
module gbl_conv_chan (
    input  logic                       clk,
    input  logic                       en,
    input  gbl_pkg::chan_win_t         taps,
    input  gbl_pkg::coef_arr_t         coefs,
    output logic [gbl_pkg::PIX_W-1:0]  filt
);

    logic [gbl_pkg::COEFS-1:0][gbl_pkg::SUM_W-1:0]  sums;
    logic [gbl_pkg::COEFS-1:0][gbl_pkg::SUM_W-1:0]  sums_reg;
    logic [gbl_pkg::COEFS-1:0][gbl_pkg::PROD_W-1:0] prod_next;
    logic [gbl_pkg::COEFS-1:0][gbl_pkg::PROD_W-1:0] prod_reg;
    logic [gbl_pkg::ACC_W-1:0]                      acc;
    logic [gbl_pkg::ACC_W-gbl_pkg::FRAC_W-1:0]      floored;

    // Add the taps that share a coefficient.
    always_comb
    begin
        sums = '0;
        for (int di = 0; di < gbl_pkg::TAPS; di++)
        begin
            for (int dj = 0; dj < gbl_pkg::TAPS; dj++)
            begin
                sums[gbl_pkg::tap_class(di, dj)] = sums[gbl_pkg::tap_class(di, dj)]
                    + gbl_pkg::SUM_W'(taps[di][dj]);
            end
        end
    end

    // One product per coefficient class.
    always_comb
    begin
        for (int k = 0; k < gbl_pkg::COEFS; k++)
        begin
            prod_next[k] = gbl_pkg::PROD_W'(sums_reg[k]) * gbl_pkg::PROD_W'(coefs[k]);
        end
    end

    // Class sums and products advance with the pipeline.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sums_reg <= sums;
            prod_reg <= prod_next;
        end
    end

    // Final sum, floor of the fraction and saturation at full scale.
    always_comb
    begin
        acc = '0;
        for (int k = 0; k < gbl_pkg::COEFS; k++)
        begin
            acc = acc + gbl_pkg::ACC_W'(prod_reg[k]);
        end
        floored = acc[gbl_pkg::ACC_W-1:gbl_pkg::FRAC_W];
        if (|floored[gbl_pkg::ACC_W-gbl_pkg::FRAC_W-1:gbl_pkg::PIX_W])
        begin
            filt = '1;
        end
        else
        begin
            filt = floored[gbl_pkg::PIX_W-1:0];
        end
    end

endmodule

// ===== hdl/gaussian_blur_5x5_rgb.sv =====
// A result passes stages s1, s2, s3 and s4 and the output register once the
// transaction that releases it is accepted (two rows plus two pixels after its own pixel).
// Throughput: one transaction per cycle while no result waits at the output; the line
// store and pass-through ring are single-port-read memories read at most once per transaction.
// Reset clears the positions, the owed count and all valid flags at once;
// registers return to 640x480 and the default kernel. No clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 5x5 RGB Gaussian blur
// Streaming blur with a four-line store, a chain of window column cells and
// three channel convolvers; edge pixels and flushed pixels pass through.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_rgb (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  gbl_pkg::in_item_t                    item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output gbl_pkg::out_item_t                   result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gbl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gbl_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int PIX_BITS  = $bits(gbl_pkg::pix_t);
    localparam int LINE_BITS = $bits(gbl_pkg::line_word_t);

    // Configuration registers.
    logic [gbl_pkg::WID_W-1:0] frame_width_reg, frame_width_next;
    logic [gbl_pkg::ROW_W-1:0] frame_height_reg, frame_height_next;
    gbl_pkg::coef_arr_t        coef_reg, coef_next;
    logic                      restart;

    // Stream position state.
    logic [gbl_pkg::COL_W-1:0]  in_col_reg, in_col_next;
    logic [gbl_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic [gbl_pkg::ROW_W-1:0]  out_row_reg, out_row_next;
    logic [gbl_pkg::PEND_W-1:0] pending_reg, pending_next;
    logic [gbl_pkg::PEND_W-1:0] wr_ptr_reg, wr_ptr_next;

    // Pipeline.
    logic             en;
    logic             acc;
    logic             push;
    logic             emit;
    logic             border;
    logic [gbl_pkg::PEND_W-1:0] thr;
    logic [gbl_pkg::WID_W-1:0]  in_col_inc;
    logic [gbl_pkg::WID_W-1:0]  out_col_inc;
    logic [gbl_pkg::ROW_W-1:0]  out_row_inc;
    logic [gbl_pkg::WID_W-1:0]  out_col_ext;
    gbl_pkg::stage_t  s1_reg, s1_next;
    gbl_pkg::stage_t  s2_reg, s2_next;
    gbl_pkg::stage_t  s3_reg;
    gbl_pkg::stage_t  s4_reg;
    gbl_pkg::pix_t    in_pix;
    gbl_pkg::pix_t    ring_rd;
    gbl_pkg::line_word_t line_rd;
    gbl_pkg::line_word_t line_wr;
    gbl_pkg::column_t    new_col;
    gbl_pkg::column_t    cell_col [gbl_pkg::TAPS];
    logic                win_shift;
    gbl_pkg::chan_win_t  win_r, win_g, win_b;
    logic [gbl_pkg::PIX_W-1:0] filt_r, filt_g, filt_b;
    logic                      out_valid_reg;
    gbl_pkg::out_item_t        out_item_reg;

    // Whole pipeline advances unless a result waits at the output.
    assign en         = !out_valid_reg || result_ready;
    assign item_ready = en;
    assign acc        = item_valid && en;
    assign cfg_ready  = 1'b1;

    // Register writes with size clamping; size writes restart the stream.
    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        coef_next         = coef_reg;
        restart           = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                gbl_pkg::REG_FRAME_WIDTH:
                begin
                    restart = 1'b1;
                    if (cfg_data[gbl_pkg::FW_FIELD_W-1:0] <
                        gbl_pkg::FW_FIELD_W'(gbl_pkg::MIN_SIZE))
                    begin
                        frame_width_next = gbl_pkg::WID_W'(gbl_pkg::MIN_SIZE);
                    end
                    else if (32'(cfg_data[gbl_pkg::FW_FIELD_W-1:0]) >
                             32'(gbl_pkg::MAX_WIDTH))
                    begin
                        frame_width_next = gbl_pkg::WID_W'(gbl_pkg::MAX_WIDTH);
                    end
                    else
                    begin
                        frame_width_next =
                            gbl_pkg::WID_W'(cfg_data[gbl_pkg::FW_FIELD_W-1:0]);
                    end
                end
                gbl_pkg::REG_FRAME_HEIGHT:
                begin
                    restart = 1'b1;
                    if (cfg_data[gbl_pkg::FH_FIELD_W-1:0] <
                        gbl_pkg::FH_FIELD_W'(gbl_pkg::MIN_SIZE))
                    begin
                        frame_height_next = gbl_pkg::ROW_W'(gbl_pkg::MIN_SIZE);
                    end
                    else
                    begin
                        frame_height_next = cfg_data[gbl_pkg::FH_FIELD_W-1:0];
                    end
                end
                gbl_pkg::REG_COEF_D0: coef_next[0] = cfg_data;
                gbl_pkg::REG_COEF_D1: coef_next[1] = cfg_data;
                gbl_pkg::REG_COEF_D2: coef_next[2] = cfg_data;
                gbl_pkg::REG_COEF_D4: coef_next[3] = cfg_data;
                gbl_pkg::REG_COEF_D5: coef_next[4] = cfg_data;
                gbl_pkg::REG_COEF_D8: coef_next[5] = cfg_data;
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // Front stage: decide whether this transaction releases a result.
    always_comb
    begin
        push   = !item.cmd;
        in_pix = '{red: item.red_in, green: item.green_in, blue: item.blue_in};
        thr    = gbl_pkg::PEND_W'({frame_width_reg, 1'b0}) +
                 gbl_pkg::PEND_W'(2 * gbl_pkg::EDGE / 2);
        emit   = push ? (pending_reg == thr) : (pending_reg != '0);

        out_col_ext = gbl_pkg::WID_W'(out_col_reg);
        border = (out_row_reg < gbl_pkg::ROW_W'(gbl_pkg::EDGE)) ||
                 (out_row_reg >= frame_height_reg - gbl_pkg::ROW_W'(gbl_pkg::EDGE)) ||
                 (out_col_ext < gbl_pkg::WID_W'(gbl_pkg::EDGE)) ||
                 (out_col_ext >= frame_width_reg - gbl_pkg::WID_W'(gbl_pkg::EDGE));

        s1_next.push      = acc && push;
        s1_next.emit      = acc && emit;
        s1_next.filter    = push && emit && !border;
        s1_next.frame_end = (out_row_reg == frame_height_reg - gbl_pkg::ROW_W'(1)) &&
                            (out_col_ext == frame_width_reg - gbl_pkg::WID_W'(1));
        s1_next.col       = in_col_reg;
        s1_next.pix       = in_pix;

        // Positions and owed count.
        in_col_next  = in_col_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pending_next = pending_reg;
        wr_ptr_next  = wr_ptr_reg;
        in_col_inc   = gbl_pkg::WID_W'(in_col_reg) + gbl_pkg::WID_W'(1);
        out_col_inc  = out_col_ext + gbl_pkg::WID_W'(1);
        out_row_inc  = out_row_reg + gbl_pkg::ROW_W'(1);
        if (acc)
        begin
            if (push)
            begin
                wr_ptr_next = wr_ptr_reg + gbl_pkg::PEND_W'(1);
                if (in_col_inc >= frame_width_reg)
                begin
                    in_col_next = '0;
                end
                else
                begin
                    in_col_next = gbl_pkg::COL_W'(in_col_inc);
                end
                if (!emit)
                begin
                    pending_next = pending_reg + gbl_pkg::PEND_W'(1);
                end
            end
            else if (emit)
            begin
                pending_next = pending_reg - gbl_pkg::PEND_W'(1);
            end
            if (emit)
            begin
                if (out_col_inc >= frame_width_reg)
                begin
                    out_col_next = '0;
                    if (out_row_inc >= frame_height_reg)
                    begin
                        out_row_next = '0;
                    end
                    else
                    begin
                        out_row_next = out_row_inc;
                    end
                end
                else
                begin
                    out_col_next = gbl_pkg::COL_W'(out_col_inc);
                end
            end
        end
        if (restart)
        begin
            in_col_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            pending_next = '0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= gbl_pkg::WIDTH_RST;
            frame_height_reg <= gbl_pkg::HEIGHT_RST;
            for (int k = 0; k < gbl_pkg::COEFS; k++)
            begin
                coef_reg[k] <= gbl_pkg::COEF_RST[k];
            end
            in_col_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            pending_reg   <= '0;
            wr_ptr_reg    <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            s4_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            coef_reg         <= coef_next;
            in_col_reg       <= in_col_next;
            out_col_reg      <= out_col_next;
            out_row_reg      <= out_row_next;
            pending_reg      <= pending_next;
            wr_ptr_reg       <= wr_ptr_next;
            if (en)
            begin
                s1_reg        <= s1_next;
                s2_reg        <= s2_next;
                s3_reg        <= s2_reg;
                s4_reg        <= s3_reg;
                out_valid_reg <= s4_reg.emit;
            end
        end
    end

    // Ring of recent pixels: source of pass-through and flushed results.
    gbl_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (gbl_pkg::RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (acc && push),
        .waddr (wr_ptr_reg),
        .wdata (in_pix),
        .re    (acc),
        .raddr (wr_ptr_reg - pending_reg),
        .rdata (ring_rd)
    );

    // Line store: one word per column holding the four rows above.
    gbl_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (gbl_pkg::MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (en && s1_reg.push),
        .waddr (s1_reg.col),
        .wdata (line_wr),
        .re    (acc && push),
        .raddr (in_col_reg),
        .rdata (line_rd)
    );

    // Second stage: build the new window column and the updated line word.
    always_comb
    begin
        line_wr[0] = s1_reg.pix;
        for (int k = 1; k < gbl_pkg::LINES; k++)
        begin
            line_wr[k] = line_rd[k-1];
        end
        new_col[gbl_pkg::TAPS-1] = s1_reg.pix;
        for (int di = 0; di < gbl_pkg::LINES; di++)
        begin
            new_col[di] = line_rd[gbl_pkg::LINES-1-di];
        end
        s2_next     = s1_reg;
        s2_next.pix = ring_rd;
    end

    assign win_shift = en && s1_reg.push;

    // Chain of window column cells; the newest column enters at the top end.
    for (genvar c = 0; c < gbl_pkg::TAPS; c++)
    begin : g_cell
        gbl_win_cell u_cell (
            .clk     (clk),
            .shift   (win_shift),
            .col_in  ((c == gbl_pkg::TAPS - 1) ? new_col : cell_col[(c + 1) % gbl_pkg::TAPS]),
            .col_out (cell_col[c])
        );
    end

    // Split the window into color planes.
    always_comb
    begin
        for (int di = 0; di < gbl_pkg::TAPS; di++)
        begin
            for (int dj = 0; dj < gbl_pkg::TAPS; dj++)
            begin
                win_r[di][dj] = cell_col[dj][di].red;
                win_g[di][dj] = cell_col[dj][di].green;
                win_b[di][dj] = cell_col[dj][di].blue;
            end
        end
    end

    gbl_conv_chan u_conv_r (
        .clk   (clk),
        .en    (en),
        .taps  (win_r),
        .coefs (coef_reg),
        .filt  (filt_r)
    );

    gbl_conv_chan u_conv_g (
        .clk   (clk),
        .en    (en),
        .taps  (win_g),
        .coefs (coef_reg),
        .filt  (filt_g)
    );

    gbl_conv_chan u_conv_b (
        .clk   (clk),
        .en    (en),
        .taps  (win_b),
        .coefs (coef_reg),
        .filt  (filt_b)
    );

    // Output register: filtered sum or pass-through pixel.
    always_ff @(posedge clk)
    begin
        if (en && s4_reg.emit)
        begin
            out_item_reg.frame_end <= s4_reg.frame_end;
            if (s4_reg.filter)
            begin
                out_item_reg.red_out   <= filt_r;
                out_item_reg.green_out <= filt_g;
                out_item_reg.blue_out  <= filt_b;
            end
            else
            begin
                out_item_reg.red_out   <= s4_reg.pix.red;
                out_item_reg.green_out <= s4_reg.pix.green;
                out_item_reg.blue_out  <= s4_reg.pix.blue;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule
